@@ sv/vns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vns_pkg
// Shared types for the vector normalize/scale pipeline.
// ----------------------------------------------------------------------------
package vns_pkg;

    localparam int unsigned NUM_LANES = 3;

    // Control that travels alongside each vector through the pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic [NUM_LANES-1:0] rneg;
    } t_ctl;

endpackage

@@ sv/vns_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vns_front
// Front stages: magnitudes, products, sum of squares and squared numerators.
// ----------------------------------------------------------------------------
module vns_front #(
    parameter int unsigned W  = 32,
    parameter int unsigned SW = 2 * W + 2,
    parameter int unsigned EW = 4 * W + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [2:0][W-1:0]    i_comp,
    input  logic [W-1:0]         i_len,
    output vns_pkg::t_ctl        o_ctl,
    output logic [SW-1:0]        o_sum,
    output logic [2:0][EW-1:0]   o_num
);

    logic [2:0][W-1:0]   mag;
    logic [W-1:0]        lmag;
    logic                lneg;

    // stage 1
    logic                r_v1;
    logic [2:0]          r_rneg1;
    logic [2:0][2*W-1:0] r_prod1;
    logic [2:0][2*W-1:0] r_sq1;
    // stage 2
    logic                r_v2;
    logic [2:0]          r_rneg2;
    logic [SW-1:0]       r_sum2;
    logic [2:0][2*W-1:0] r_hh2;
    logic [2:0][2*W-1:0] r_hl2;
    logic [2:0][2*W-1:0] r_ll2;
    // stage 3
    vns_pkg::t_ctl       r_ctl3;
    logic [SW-1:0]       r_sum3;
    logic [2:0][EW-1:0]  r_num3;

    always_comb begin
        lneg = i_len[W-1];
        lmag = lneg ? (~i_len + W'(1)) : i_len;
        for (int i = 0; i < 3; i++) begin
            mag[i] = i_comp[i][W-1] ? (~i_comp[i] + W'(1)) : i_comp[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ctl3 <= '0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_ctl3.valid <= r_v2;
            r_ctl3.rneg  <= r_rneg2;
            r_ctl3.zero  <= (r_sum2 == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rneg1[i] <= i_comp[i][W-1] ^ lneg;
            r_prod1[i] <= (2*W)'(mag[i]) * (2*W)'(lmag);
            r_sq1[i]   <= (2*W)'(mag[i]) * (2*W)'(mag[i]);
            // numerator squared, split in W-bit halves
            r_hh2[i]   <= (2*W)'(r_prod1[i][2*W-1:W]) * (2*W)'(r_prod1[i][2*W-1:W]);
            r_hl2[i]   <= (2*W)'(r_prod1[i][2*W-1:W]) * (2*W)'(r_prod1[i][W-1:0]);
            r_ll2[i]   <= (2*W)'(r_prod1[i][W-1:0]) * (2*W)'(r_prod1[i][W-1:0]);
            r_num3[i]  <= (EW'(r_hh2[i]) << (2*W)) + (EW'(r_hl2[i]) << (W+1))
                          + EW'(r_ll2[i]);
        end
        r_rneg2 <= r_rneg1;
        r_sum2  <= SW'(r_sq1[0]) + SW'(r_sq1[1]) + SW'(r_sq1[2]);
        r_sum3  <= r_sum2;
    end

    assign o_ctl = r_ctl3;
    assign o_sum = r_sum3;
    assign o_num = r_num3;

endmodule

@@ sv/vns_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vns_step
// One quotient bit per stage: keeps E = P^2 - q^2*S and F = q*S per lane.
// ----------------------------------------------------------------------------
module vns_step #(
    parameter int unsigned W  = 32,
    parameter int unsigned K  = 0,
    parameter int unsigned SW = 2 * W + 2,
    parameter int unsigned EW = 4 * W + 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vns_pkg::t_ctl      i_ctl,
    input  logic [SW-1:0]      i_sum,
    input  logic [2:0][EW-1:0] i_rem,
    input  logic [2:0][EW-1:0] i_acc,
    input  logic [2:0][W-1:0]  i_q,
    output vns_pkg::t_ctl      o_ctl,
    output logic [SW-1:0]      o_sum,
    output logic [2:0][EW-1:0] o_rem,
    output logic [2:0][EW-1:0] o_acc,
    output logic [2:0][W-1:0]  o_q
);

    logic [EW-1:0]      sum_w;
    logic [2:0][EW-1:0] delta;
    vns_pkg::t_ctl      r_ctl;
    logic [SW-1:0]      r_sum;
    logic [2:0][EW-1:0] r_rem;
    logic [2:0][EW-1:0] r_acc;
    logic [2:0][W-1:0]  r_q;

    assign sum_w = EW'(i_sum);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // (q + 2^K)^2 S - q^2 S
            delta[i] = (i_acc[i] << (K + 1)) + (sum_w << (2 * K));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= i_sum;
        for (int i = 0; i < 3; i++) begin
            if (delta[i] <= i_rem[i]) begin
                r_rem[i] <= i_rem[i] - delta[i];
                r_acc[i] <= i_acc[i] + (sum_w << K);
                r_q[i]   <= i_q[i] | (W'(1) << K);
            end else begin
                r_rem[i] <= i_rem[i];
                r_acc[i] <= i_acc[i];
                r_q[i]   <= i_q[i];
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_sum = r_sum;
    assign o_rem = r_rem;
    assign o_acc = r_acc;
    assign o_q   = r_q;

endmodule

@@ sv/vector3_normalize_scale_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_scale_top
// Scales a signed fixed-point 3-vector to the programmed length.
// ----------------------------------------------------------------------------
// Fully pipelined: one vector per clock, every cycle. busy is always low and
// the receiver cannot stall; each result is shown for exactly one cycle. The
// quotient pipeline resolves one bit of all three components per stage by an
// exact compare against P^2 - q^2*S, so results match floor(|a*L|/sqrt(S))
// bit for bit. Three front stages form |a*L|, its square and the sum of
// squares S; one output stage saturates, applies the sign and handles the
// zero vector (outputs 0, o_zero_vector high). The scale length register is
// sampled when a vector enters; write it only while no transaction is in
// flight. o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module vector3_normalize_scale_top #(
    parameter int unsigned COMPONENT_WIDTH = 32,
    parameter int unsigned FRACTION_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [COMPONENT_WIDTH-1:0] i_in_x,
    input  logic [COMPONENT_WIDTH-1:0] i_in_y,
    input  logic [COMPONENT_WIDTH-1:0] i_in_z,
    output logic                       o_valid,
    output logic [COMPONENT_WIDTH-1:0] o_out_x,
    output logic [COMPONENT_WIDTH-1:0] o_out_y,
    output logic [COMPONENT_WIDTH-1:0] o_out_z,
    output logic                       o_zero_vector,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [COMPONENT_WIDTH-1:0] i_cfg_scale_length
);

    localparam int unsigned W  = COMPONENT_WIDTH;
    localparam int unsigned SW = 2 * W + 2;
    localparam int unsigned EW = 4 * W + 4;

    logic [W-1:0]       r_scale;
    logic [2:0][W-1:0]  comp;

    // pipeline taps between quotient stages, index 0 = front output
    vns_pkg::t_ctl      ctl_s [W+1];
    logic [SW-1:0]      sum_s [W+1];
    logic [2:0][EW-1:0] rem_s [W+1];
    logic [2:0][EW-1:0] acc_s [W+1];
    logic [2:0][W-1:0]  q_s   [W+1];

    logic [2:0][W-1:0]  res;
    logic [W-1:0]       lim_pos;
    logic [W-1:0]       lim_neg;
    logic [W-1:0]       qc;

    logic               r_valid;
    logic               r_zero;
    logic [2:0][W-1:0]  r_res;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign comp        = {i_in_z, i_in_y, i_in_x};

    // scale length register, reset to 1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= W'(1) << FRACTION_BITS;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_scale_length;
        end
    end

    vns_front #(.W(W), .SW(SW), .EW(EW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_comp  (comp),
        .i_len   (r_scale),
        .o_ctl   (ctl_s[0]),
        .o_sum   (sum_s[0]),
        .o_num   (rem_s[0])
    );

    assign acc_s[0] = '0;
    assign q_s[0]   = '0;

    // MSB first: stage j resolves bit W-1-j
    for (genvar j = 0; j < W; j++) begin : g_step
        vns_step #(.W(W), .K(W - 1 - j), .SW(SW), .EW(EW)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_s[j]),
            .i_sum   (sum_s[j]),
            .i_rem   (rem_s[j]),
            .i_acc   (acc_s[j]),
            .i_q     (q_s[j]),
            .o_ctl   (ctl_s[j+1]),
            .o_sum   (sum_s[j+1]),
            .o_rem   (rem_s[j+1]),
            .o_acc   (acc_s[j+1]),
            .o_q     (q_s[j+1])
        );
    end

    // saturate to the signed range, then apply the sign
    assign lim_pos = (W'(1) << (W - 1)) - W'(1);
    assign lim_neg = W'(1) << (W - 1);

    always_comb begin
        qc = '0;
        for (int i = 0; i < 3; i++) begin
            if (ctl_s[W].rneg[i]) begin
                qc     = (q_s[W][i] > lim_neg) ? lim_neg : q_s[W][i];
                res[i] = ~qc + W'(1);
            end else begin
                qc     = (q_s[W][i] > lim_pos) ? lim_pos : q_s[W][i];
                res[i] = qc;
            end
            if (ctl_s[W].zero) begin
                res[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl_s[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= ctl_s[W].zero;
        r_res  <= res;
    end

    assign o_valid       = r_valid;
    assign o_zero_vector = r_zero;
    assign o_out_x       = r_res[0];
    assign o_out_y       = r_res[1];
    assign o_out_z       = r_res[2];

endmodule

@@ sv/vns_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vns_checker
// Port-level checks for the normalize/scale pipeline.
// ----------------------------------------------------------------------------
module vns_checker #(
    parameter int unsigned COMPONENT_WIDTH = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [COMPONENT_WIDTH-1:0] o_out_x,
    input logic [COMPONENT_WIDTH-1:0] o_out_y,
    input logic [COMPONENT_WIDTH-1:0] o_out_z,
    input logic                       o_zero_vector,
    input logic                       o_cfg_ready
);

    localparam int unsigned LAT = COMPONENT_WIDTH + 4;

    // every result traces back to a start a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching transaction");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |->
            (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("zero vector with nonzero result");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("pipeline refused a transaction");

endmodule

bind vector3_normalize_scale_top vns_checker #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_vns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_out_x       (o_out_x),
    .o_out_y       (o_out_y),
    .o_out_z       (o_out_z),
    .o_zero_vector (o_zero_vector),
    .o_cfg_ready   (o_cfg_ready)
);
